/* hw/rtl/ofus_pkg.sv */
// shared types and constants for the oldest-first unit select block
package ofus_pkg;

	localparam int AGE_W     = 48;
	localparam int MASK_W    = 8;
	localparam int FU_IDX_W  = 3;
	localparam int CNT_W     = 4;
	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 64;

	localparam logic MODE_CLEAR = 1'b0;
	localparam logic MODE_SCHED = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

/* hw/rtl/oldest_first_unit_select.sv */
// oldest-first unit select: places ready ops onto functional-unit slots, top level
//
// input channel s_*: one beat per op or per clear. s_tuser is the mode (0 clears every
// slot and starts a new cycle, 1 schedules one op). s_tdata carries the op age and the
// mask of units that can run it.
// output channel m_*: one beat per input beat, in order, with granted, the slot index,
// whether a younger op was evicted, its age, and the number of occupied slots.
// a schedule beat walks the slots one per cycle through a single age
// comparator; the walk stops at the first empty eligible slot. s_tready is high only
// between ops, so the block takes no new op or clear until the last one has left
// its final step.
// the result sits in an output register; while the receiver stalls, a finished op waits
// there and the block holds the next op at its final step until the register frees.
// mask bits for units at or above NUM_UNITS are ignored.
// reset (arst_n low) empties every slot, zeroes the used count and drops m_tvalid.
module oldest_first_unit_select #(
	parameter int NUM_UNITS = 8,
	parameter int AGE_BITS  = 48
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// op_age [47:0], eligible_fu_mask [55:48]
	input  logic [ofus_pkg::S_TDATA_W-1:0] s_tdata,
	// mode [0]
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// granted [0], fu_index [3:1], displaced [4], displaced_age [52:5], slots_used [56:53]
	output logic [ofus_pkg::M_TDATA_W-1:0] m_tdata
);

	import ofus_pkg::*;

	localparam int LIMIT = (NUM_UNITS < MASK_W) ? NUM_UNITS : MASK_W;
	localparam int IDX_W = (LIMIT > 1) ? $clog2(LIMIT) : 1;

	state_t st_q, st_d;

	logic                 s_ready;
	logic                 scan_en;
	logic                 finish;
	logic                 out_free;

	logic [IDX_W-1:0]     idx_q;
	logic                 mode_q;
	logic [AGE_BITS-1:0]  age_q;
	logic [LIMIT-1:0]     mask_q;
	logic                 found_q;
	logic [IDX_W-1:0]     pick_q;
	logic                 have_q;
	logic [IDX_W-1:0]     victim_q;
	logic [AGE_BITS-1:0]  best_q;
	logic [CNT_W-1:0]     used_q;

	logic [LIMIT-1:0]     slot_valid_q;
	logic [AGE_BITS-1:0]  slot_age_q [LIMIT];

	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic [AGE_BITS-1:0]  cur_age;
	logic                 elig;
	logic                 hit_empty;
	logic                 younger;
	logic                 last;

	logic                 res_granted;
	logic                 res_displaced;
	logic [IDX_W-1:0]     res_idx;
	logic [AGE_W-1:0]     res_age;
	logic [CNT_W-1:0]     used_next;

	// one slot per cycle through the shared comparator
	assign cur_age   = slot_age_q[idx_q];
	assign elig      = mask_q[idx_q];
	assign hit_empty = elig && !slot_valid_q[idx_q];
	assign younger   = elig && slot_valid_q[idx_q] && (age_q < cur_age) &&
	                   (!have_q || (cur_age > best_q));
	assign last      = (idx_q == IDX_W'(LIMIT - 1));

	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					st_d = (s_tuser == MODE_SCHED) ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				if (hit_empty || last) begin
					st_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_ready = 1'b0;
		scan_en = 1'b0;
		finish  = 1'b0;
		case (st_q)
			ST_IDLE: s_ready = 1'b1;
			ST_SCAN: scan_en = 1'b1;
			ST_DONE: finish  = out_free;
			default: begin
				s_ready = 1'b0;
			end
		endcase
	end

	assign res_granted   = (mode_q == MODE_SCHED) && (found_q || have_q);
	assign res_displaced = (mode_q == MODE_SCHED) && !found_q && have_q;
	assign res_idx       = !res_granted ? '0 : (found_q ? pick_q : victim_q);
	assign res_age       = res_displaced ? AGE_W'(best_q) : '0;

	always_comb begin
		if (mode_q == MODE_CLEAR) begin
			used_next = '0;
		end else if (found_q && (used_q != {CNT_W{1'b1}})) begin
			used_next = used_q + CNT_W'(1);
		end else begin
			used_next = used_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			idx_q      <= '0;
			found_q    <= 1'b0;
			have_q     <= 1'b0;
			used_q     <= '0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < LIMIT; i++) begin
				slot_valid_q[i] <= 1'b0;
			end
		end else begin
			st_q <= st_d;
			if (s_ready && s_tvalid) begin
				idx_q   <= '0;
				found_q <= 1'b0;
				have_q  <= 1'b0;
			end
			if (scan_en) begin
				if (hit_empty) begin
					found_q <= 1'b1;
				end else if (younger) begin
					have_q <= 1'b1;
				end
				if (!hit_empty && !last) begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
			if (finish) begin
				used_q <= used_next;
				if (mode_q == MODE_CLEAR) begin
					for (int i = 0; i < LIMIT; i++) begin
						slot_valid_q[i] <= 1'b0;
					end
				end else if (found_q) begin
					slot_valid_q[pick_q] <= 1'b1;
				end
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_ready && s_tvalid) begin
			mode_q <= s_tuser;
			age_q  <= AGE_BITS'(s_tdata[AGE_W-1:0]);
			mask_q <= s_tdata[AGE_W +: LIMIT];
		end
		if (scan_en) begin
			if (hit_empty) begin
				pick_q <= idx_q;
			end else if (younger) begin
				victim_q <= idx_q;
				best_q   <= cur_age;
			end
		end
		if (finish) begin
			if (res_granted) begin
				slot_age_q[res_idx] <= age_q;
			end
			m_tdata_q <= {{(M_TDATA_W - 1 - FU_IDX_W - 1 - AGE_W - CNT_W){1'b0}},
			              used_next, res_age, res_displaced,
			              FU_IDX_W'(res_idx), res_granted};
		end
	end

	assign s_tready = s_ready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_used_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(slot_valid_q) == int'(used_q))
		else $error("used count does not match occupied slots");

	a_used_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		int'(used_q) <= LIMIT)
		else $error("used count above slot count");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted a beat while an op was in progress");

	a_displace_implies_grant: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1 + FU_IDX_W] |-> m_tdata[0])
		else $error("eviction reported without a grant");

endmodule

/* tb/testbench.sv */
// self-checking testbench for the oldest-first unit select block
module testbench;
	import ofus_pkg::*;

	localparam int NUM_UNITS   = 8;
	localparam int AGE_BITS    = 48;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_OPS  = 600;

	typedef struct packed {
		logic [CNT_W-1:0]    slots_used;
		logic [AGE_W-1:0]    displaced_age;
		logic                displaced;
		logic [FU_IDX_W-1:0] fu_index;
		logic                granted;
	} grant_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;

	// predictor copy of the slot table
	logic [NUM_UNITS-1:0] occ_valid;
	logic [AGE_W-1:0]     occ_age [NUM_UNITS];
	logic [CNT_W-1:0]     occ_count;

	grant_t grant_q [$];
	grant_t got_beat;
	grant_t want_beat;
	int     errors;
	int     cycle_cnt;
	int     burst_left;
	int     rx_tick;
	int     rx_mode;

	oldest_first_unit_select #(
		.NUM_UNITS(NUM_UNITS),
		.AGE_BITS (AGE_BITS)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// oldest-first placement of one op, or a clear
	function automatic grant_t compute_grant(input logic mode, input logic [AGE_W-1:0] age,
			input logic [MASK_W-1:0] mask);
		grant_t r;
		logic   found;
		logic   have_victim;
		int     victim;
		r = '0;
		found = 1'b0;
		have_victim = 1'b0;
		victim = 0;
		if (mode == MODE_CLEAR) begin
			occ_valid = '0;
			occ_count = '0;
		end else begin
			for (int i = 0; i < NUM_UNITS && i < MASK_W; i++) begin
				if (mask[i] && !found) begin
					if (!occ_valid[i]) begin
						found = 1'b1;
						r.fu_index = i[FU_IDX_W-1:0];
					end else if (age < occ_age[i] &&
							(!have_victim || occ_age[i] > occ_age[victim])) begin
						have_victim = 1'b1;
						victim = i;
					end
				end
			end
			if (found) begin
				r.granted = 1'b1;
				occ_valid[r.fu_index] = 1'b1;
				occ_age[r.fu_index] = age;
				if (occ_count < 15)
					occ_count = occ_count + 1'b1;
			end else if (have_victim) begin
				r.granted = 1'b1;
				r.displaced = 1'b1;
				r.fu_index = victim[FU_IDX_W-1:0];
				r.displaced_age = occ_age[victim];
				occ_age[victim] = age;
			end
		end
		r.slots_used = occ_count;
		return r;
	endfunction

	function automatic logic [AGE_W-1:0] rand_age();
		logic [63:0] t;
		t = {$urandom, $urandom};
		return t[AGE_W-1:0];
	endfunction

	function automatic logic [MASK_W-1:0] rand_mask();
		logic [MASK_W-1:0] m;
		case ($urandom_range(0, 15))
			0: m = '0;
			1, 2, 3, 4: m = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
			5: m = '1;
			default: m = MASK_W'($urandom);
		endcase
		return m;
	endfunction

	// sender pacing: bursts of random length, random gaps between them
	task automatic sender_pace();
		int gap;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) :
				$urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	task automatic send_beat(input logic mode, input logic [AGE_W-1:0] age,
			input logic [MASK_W-1:0] mask);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {mask, age};
		do @(posedge clk); while (!s_tready);
		grant_q.push_back(compute_grant(mode, age, mask));
		sender_pace();
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (grant_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [AGE_W-1:0] want_v,
			input logic [AGE_W-1:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
			errors++;
		end
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_beat = m_tdata[$bits(grant_t)-1:0];
			if (grant_q.size() == 0) begin
				$display("%0t: result beat with nothing pending, expected none, actual %h",
					$time, m_tdata);
				errors++;
			end else begin
				want_beat = grant_q.pop_front();
				check_field("granted", want_beat.granted, got_beat.granted);
				check_field("fu_index", want_beat.fu_index, got_beat.fu_index);
				check_field("displaced", want_beat.displaced, got_beat.displaced);
				check_field("displaced_age", want_beat.displaced_age, got_beat.displaced_age);
				check_field("slots_used", want_beat.slots_used, got_beat.slots_used);
			end
		end
	end

	// receiver stalls on its own pattern, switching between random styles
	always @(negedge clk) begin
		rx_tick++;
		if (rx_tick % 64 == 0)
			rx_mode = $urandom_range(0, 3);
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= $urandom_range(0, 1);
			2: m_tready <= (rx_tick % 4 == 0);
			default: m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// extremes, empty mask, equal ages, ties, displacement and clears
	task automatic test_directed_cases();
		send_beat(MODE_SCHED, 48'd100, 8'h00);
		send_beat(MODE_SCHED, '1, 8'h80);
		send_beat(MODE_SCHED, '0, 8'h80);
		send_beat(MODE_SCHED, '0, 8'h80);
		send_beat(MODE_CLEAR, '1, '1);
		send_beat(MODE_SCHED, 48'd50, 8'h01);
		send_beat(MODE_SCHED, 48'd50, 8'h02);
		send_beat(MODE_SCHED, 48'd10, 8'h03);
		for (int i = 0; i < 6; i++)
			send_beat(MODE_SCHED, 48'd20 + i, 8'hff);
		send_beat(MODE_SCHED, 48'd30, 8'hff);
		send_beat(MODE_SCHED, 48'd9, 8'hff);
		send_beat(MODE_SCHED, 48'd100, 8'hff);
		send_beat(MODE_SCHED, 48'd5, 8'haa);
		send_beat(MODE_SCHED, '1, 8'h55);
		send_beat(MODE_CLEAR, '0, '0);
		send_beat(MODE_SCHED, 48'd1, 8'h55);
		send_beat(MODE_CLEAR, rand_age(), rand_mask());
	endtask

	// sender holds off until every result is back, then resumes
	task automatic test_drain_pause();
		for (int i = 0; i < 6; i++)
			send_beat(MODE_SCHED, rand_age(), rand_mask());
		wait_drained();
		for (int i = 0; i < 4; i++)
			send_beat(MODE_SCHED, rand_age(), rand_mask());
		send_beat(MODE_CLEAR, rand_age(), rand_mask());
	endtask

	// scheduling cycles: a clear, then a run of ops, mostly with close ages, with stray clears
	task automatic test_random_cycles();
		int               sent;
		int               ops;
		logic [AGE_W-1:0] base;
		logic [AGE_W-1:0] age;
		sent = 0;
		while (sent < RANDOM_OPS) begin
			send_beat(MODE_CLEAR, rand_age(), rand_mask());
			sent++;
			base = rand_age() & ~48'hff;
			ops = $urandom_range(1, 14);
			for (int i = 0; i < ops; i++) begin
				if ($urandom_range(0, 9) == 0)
					age = rand_age();
				else
					age = base + $urandom_range(0, 15);
				if ($urandom_range(0, 19) == 0)
					send_beat(MODE_CLEAR, rand_age(), rand_mask());
				else
					send_beat(MODE_SCHED, age, rand_mask());
				sent++;
			end
			if ($urandom_range(0, 24) == 0)
				wait_drained();
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = MODE_CLEAR;
		m_tready   = 1'b0;
		occ_valid  = '0;
		occ_count  = '0;
		errors     = 0;
		cycle_cnt  = 0;
		burst_left = 1;
		rx_tick    = 0;
		rx_mode    = 0;
		for (int i = 0; i < NUM_UNITS; i++)
			occ_age[i] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_drain_pause();
		test_random_cycles();

		wait_drained();
		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
